@@ rtl/core/in_order_completion_queue_assert.svh @@
// Assertion macros shared by the queue's modules
`ifndef IN_ORDER_COMPLETION_QUEUE_ASSERT_SVH
`define IN_ORDER_COMPLETION_QUEUE_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset
`define IOCQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a cause implies an effect in the cycle after it
`define IOCQ_ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

@@ rtl/core/iocq_pkg.sv @@
package iocq_pkg;

  localparam int unsigned STATION_W = 3;
  localparam int unsigned TRAIN_W   = 8;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned MAX_RESULTS = 8;

  // Operation codes
  localparam logic OP_ENTER  = 1'b0;
  localparam logic OP_ARRIVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ENTERED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RETIRED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // Classified command from front to back
  typedef struct packed {
    logic                 invalid;
    logic                 op;
    logic [5:0]           link;
    logic [TRAIN_W-1:0]   train_id;
  } cmd_t;

  // One result word
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [TRAIN_W-1:0]   retired_train;
    logic                 caller_retired;
    logic                 first_on_link;
    logic                 link_now_empty;
    logic                 last;
  } res_t;

endpackage

@@ rtl/core/in_order_completion_queue.sv @@
// Channel   | Dir | Handshake              | Payload
// s_axis    | in  | s_axis_tvalid/tready   | tdata: op, from_station, to_station, train_id
// m_axis    | out | m_axis_tvalid/tready   | tdata: status, retired_train, caller_retired,
//           |     |                        |        first_on_link, link_now_empty; tlast
// cfg       | in  | cfg_we                 | cfg_data: link_valid_mask
// An enter or a rejected word takes the back end through S_RDCNT, S_EMIT and S_DONE. An
// arrive also scans the slots, shifts the slots down once per retired train and emits one
// result word per retired train, or one if none retires; its time is set by the single read
// port of the slot memory. After reset a pass clears the per-link counts; the front end
// holds up to two words meanwhile. A two-entry command queue lets input words be taken
// while results wait; a result word held by m_axis_tready stalls the back end.
module in_order_completion_queue #(
  parameter int unsigned STATIONS    = 8,
  parameter int unsigned QUEUE_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[0], from_station[3:1], to_station[6:4], train_id[14:7], zero[15]
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], retired_train[10:3], caller_retired[11], first_on_link[12],
  // link_now_empty[13], zero[15:14]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic                q_valid;
  logic                q_ready;
  iocq_pkg::cmd_t      q_cmd;
  iocq_pkg::res_t      res;

  iocq_front #(.STATIONS(STATIONS)) u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_op(s_axis_tdata[0]), .in_from(s_axis_tdata[3:1]),
    .in_to(s_axis_tdata[6:4]), .in_train(s_axis_tdata[14:7]),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  iocq_back #(.QUEUE_SLOTS(QUEUE_SLOTS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  // Pack the result word
  assign m_axis_tdata = {2'b00, res.link_now_empty, res.first_on_link,
                         res.caller_retired, res.retired_train, res.status};
  assign m_axis_tlast = res.last;

endmodule

@@ rtl/core/iocq_front.sv @@
module iocq_front #(
  parameter int unsigned STATIONS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [2:0]          in_from,
  input  logic [2:0]          in_to,
  input  logic [7:0]          in_train,
  output logic                q_valid,
  input  logic                q_ready,
  output iocq_pkg::cmd_t      q_cmd
);

  localparam int unsigned QDEPTH = 2;

  logic [63:0]          link_valid_mask;
  iocq_pkg::cmd_t       fifo [QDEPTH];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           fill;
  logic [5:0]           link_idx;
  logic                 bad;
  iocq_pkg::cmd_t       cmd;
  logic                 push;
  logic                 pop;

  // Hold the link mask
  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid_mask <= '0;
    end else if (cfg_we) begin
      link_valid_mask <= cfg_data;
    end
  end

  // Classify the incoming word
  always_comb begin
    link_idx = 6'((32'(in_from) * STATIONS + 32'(in_to)) & 32'h3f);
    bad = (32'(in_from) >= STATIONS) || (32'(in_to) >= STATIONS) ||
          !link_valid_mask[link_idx];
    cmd.invalid  = bad;
    cmd.op       = in_op;
    cmd.link     = link_idx;
    cmd.train_id = in_train;
  end

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = fifo[rd_ptr];

  // Advance the short command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= cmd;
  end

`include "in_order_completion_queue_assert.svh"
  `IOCQ_ASSERT_ALWAYS(a_fill_range, clk, rst, fill <= 2'd2, "queue overfilled")
  `IOCQ_ASSERT_NEXT(a_push_fill, clk, rst, push && !pop, fill == $past(fill) + 2'd1,
    "push lost")
  `IOCQ_ASSERT_NEXT(a_pop_fill, clk, rst, pop && !push, fill == $past(fill) - 2'd1,
    "pop lost")

endmodule

@@ rtl/core/iocq_back.sv @@
module iocq_back #(
  parameter int unsigned QUEUE_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  iocq_pkg::cmd_t      q_cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output iocq_pkg::res_t      res
);

  localparam int unsigned SW   = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int unsigned CW   = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned AW   = 6 + SW;
  localparam int unsigned MEMD = 64 * (1 << SW);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_RDCNT  = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_HEAD   = 9'b000010000,
    S_SHIFT  = 9'b000100000,
    S_SHWR   = 9'b001000000,
    S_EMIT   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t               state;
  // Slot store: train id and arrived flag
  logic [8:0]           slot_mem [MEMD];
  logic [8:0]           rd_data;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [8:0]           wr_data;
  logic [CW-1:0]        count_mem [64];
  logic [CW-1:0]        cnt;
  logic [SW:0]          idx;
  logic [6:0]           clr_idx;
  iocq_pkg::cmd_t       cur;
  logic                 marked;
  logic                 caller;
  logic [3:0]           nret;
  logic [7:0]           gone [iocq_pkg::MAX_RESULTS];
  logic [3:0]           emit_k;
  logic                 out_full;
  logic                 cnt_we;
  logic [CW-1:0]        cnt_wd;

  assign q_ready   = (state == S_IDLE);
  assign res_valid = out_full;

  function automatic logic [AW-1:0] addr_of(input logic [5:0] lk, input logic [SW:0] s);
    addr_of = {lk, s[SW-1:0]};
  endfunction

  // Registered slot read
  always_ff @(posedge clk) begin
    rd_data <= slot_mem[rd_addr];
    if (wr_en) slot_mem[wr_addr] <= wr_data;
  end

  // Read-address select
  always_comb begin
    rd_addr = addr_of(cur.link, idx);
  end

  // Count table, cleared by sweep
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) count_mem[clr_idx[5:0]] <= '0;
    else if (cnt_we) count_mem[cur.link] <= cnt_wd;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      out_full <= 1'b0;
      wr_en    <= 1'b0;
      cnt_we   <= 1'b0;
    end else begin
      wr_en  <= 1'b0;
      cnt_we <= 1'b0;
      if (out_full && res_ready) out_full <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 7'd1;
          if (clr_idx == 7'd63) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur    <= q_cmd;
            idx    <= '0;
            marked <= 1'b0;
            caller <= 1'b0;
            nret   <= '0;
            emit_k <= '0;
            state  <= S_RDCNT;
          end
        end
        S_RDCNT: begin
          cnt <= count_mem[cur.link];
          if (cur.invalid) begin
            emit_k <= '0;
            state  <= S_EMIT;
          end else if (cur.op == iocq_pkg::OP_ENTER) begin
            state <= S_EMIT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Check the slot bound while the slot read is issued; S_SHWR tests the data
          if (32'(idx) >= 32'(cnt) || marked) begin
            idx   <= '0;
            state <= S_HEAD;
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          if (rd_data[7:0] == cur.train_id && !rd_data[8]) begin
            // Let the flag write land before the head is read
            wr_en   <= 1'b1;
            wr_addr <= addr_of(cur.link, idx);
            wr_data <= {1'b1, rd_data[7:0]};
            marked  <= 1'b1;
            idx     <= '0;
            state   <= S_SCAN;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_HEAD: begin
          // Read slot idx; rd_data holds it in S_SHIFT
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (idx == '0) begin
            if (cnt != '0 && rd_data[8] && nret != 4'(iocq_pkg::MAX_RESULTS)) begin
              gone[nret[2:0]] <= rd_data[7:0];
              if (rd_data[7:0] == cur.train_id) caller <= 1'b1;
              nret <= nret + 4'd1;
              idx  <= idx + 1'b1;
              state <= S_HEAD;
            end else begin
              cnt_we <= 1'b1;
              cnt_wd <= cnt;
              state  <= S_EMIT;
            end
          end else if (32'(idx) < 32'(cnt)) begin
            // move slot idx down one
            wr_en   <= 1'b1;
            wr_addr <= addr_of(cur.link, idx - 1'b1);
            wr_data <= rd_data;
            idx     <= idx + 1'b1;
            state   <= S_HEAD;
          end else begin
            cnt   <= cnt - 1'b1;
            idx   <= '0;
            state <= S_HEAD;
          end
        end
        S_EMIT: begin
          if (!out_full || res_ready) begin
            out_full <= 1'b1;
            res.retired_train  <= '0;
            res.caller_retired <= 1'b0;
            res.first_on_link  <= 1'b0;
            res.link_now_empty <= 1'b0;
            res.last           <= 1'b1;
            state              <= S_DONE;
            if (cur.invalid) begin
              res.status <= iocq_pkg::ST_INVALID;
            end else if (cur.op == iocq_pkg::OP_ENTER) begin
              if (32'(cnt) >= QUEUE_SLOTS) begin
                res.status <= iocq_pkg::ST_FULL;
              end else begin
                res.status        <= iocq_pkg::ST_ENTERED;
                res.first_on_link <= (cnt == '0);
                wr_en   <= 1'b1;
                wr_addr <= addr_of(cur.link, (SW+1)'(cnt));
                wr_data <= {1'b0, cur.train_id};
                cnt_we  <= 1'b1;
                cnt_wd  <= cnt + 1'b1;
              end
            end else if (nret == '0) begin
              res.status         <= iocq_pkg::ST_NONE;
              res.link_now_empty <= (cnt == '0);
            end else begin
              res.status         <= iocq_pkg::ST_RETIRED;
              res.retired_train  <= gone[emit_k[2:0]];
              res.caller_retired <= caller;
              res.link_now_empty <= (cnt == '0);
              res.last           <= (emit_k + 4'd1 == nret);
              emit_k             <= emit_k + 4'd1;
              if (emit_k + 4'd1 != nret) state <= S_EMIT;
            end
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "in_order_completion_queue_assert.svh"
  `IOCQ_ASSERT_ALWAYS(a_onehot, clk, rst, $onehot(state), "state not one-hot")
  `IOCQ_ASSERT_ALWAYS(a_cnt_range, clk, rst, 32'(cnt) <= QUEUE_SLOTS || state == S_IDLE
    || state == S_CLEAR || state == S_RDCNT || state == S_DONE, "count beyond slots")
  `IOCQ_ASSERT_ALWAYS(a_nret, clk, rst, nret <= 4'(iocq_pkg::MAX_RESULTS) ||
    state == S_IDLE || state == S_CLEAR || state == S_RDCNT, "too many retired")

endmodule

@@ verif/in_order_completion_queue_tb.sv @@
`timescale 1ns / 100ps

// Expected result words of the completion queue, oldest first
class completion_board;
  iocq_pkg::res_t pending[$];
  int   errors;
  logic [63:0] mask;
  logic [7:0]  trains[64][$];
  logic        arrived[64][$];

  function void set_mask(logic [63:0] m);
    mask = m;
  endfunction

  // Predict the words one input item causes and queue them
  function void note_item(logic op, logic [2:0] from_st, logic [2:0] to_st,
                          logic [7:0] id);
    int   link;
    int   n;
    logic caller;
    logic [7:0] gone[$];
    iocq_pkg::res_t r;
    link = from_st * 8 + to_st;
    r = '0;
    r.last = 1'b1;
    if (!mask[link]) begin
      r.status = iocq_pkg::ST_INVALID;
      pending.push_back(r);
      return;
    end
    if (op == iocq_pkg::OP_ENTER) begin
      if (trains[link].size() >= 8) begin
        r.status = iocq_pkg::ST_FULL;
      end else begin
        r.status = iocq_pkg::ST_ENTERED;
        r.first_on_link = (trains[link].size() == 0);
        trains[link].push_back(id);
        arrived[link].push_back(1'b0);
      end
      pending.push_back(r);
      return;
    end
    // mark the first unmarked match nearest the head
    for (int i = 0; i < trains[link].size(); i++) begin
      if (trains[link][i] == id && !arrived[link][i]) begin
        arrived[link][i] = 1'b1;
        break;
      end
    end
    caller = 1'b0;
    n = 0;
    while (n < iocq_pkg::MAX_RESULTS && trains[link].size() > 0 && arrived[link][0]) begin
      gone.push_back(trains[link][0]);
      if (trains[link][0] == id) caller = 1'b1;
      void'(trains[link].pop_front());
      void'(arrived[link].pop_front());
      n++;
    end
    if (n == 0) begin
      r.status = iocq_pkg::ST_NONE;
      r.link_now_empty = (trains[link].size() == 0);
      pending.push_back(r);
      return;
    end
    foreach (gone[k]) begin
      r = '0;
      r.status = iocq_pkg::ST_RETIRED;
      r.retired_train = gone[k];
      r.caller_retired = caller;
      r.link_now_empty = (trains[link].size() == 0);
      r.last = (k == n - 1);
      pending.push_back(r);
    end
  endfunction

  // Compare one accepted word with the oldest expectation
  function void check_word(iocq_pkg::res_t got);
    iocq_pkg::res_t exp_r;
    if (pending.size() == 0) begin
      $error("unexpected result word %h", got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.status != exp_r.status) begin
      $error("status exp %0d act %0d", exp_r.status, got.status); errors++;
    end
    if (got.retired_train != exp_r.retired_train) begin
      $error("retired_train exp %0d act %0d", exp_r.retired_train, got.retired_train);
      errors++;
    end
    if (got.caller_retired != exp_r.caller_retired) begin
      $error("caller_retired exp %0d act %0d", exp_r.caller_retired, got.caller_retired);
      errors++;
    end
    if (got.first_on_link != exp_r.first_on_link) begin
      $error("first_on_link exp %0d act %0d", exp_r.first_on_link, got.first_on_link);
      errors++;
    end
    if (got.link_now_empty != exp_r.link_now_empty) begin
      $error("link_now_empty exp %0d act %0d", exp_r.link_now_empty, got.link_now_empty);
      errors++;
    end
    if (got.last != exp_r.last) begin
      $error("last exp %0d act %0d", exp_r.last, got.last); errors++;
    end
  endfunction
endclass

module in_order_completion_queue_tb;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [63:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  completion_board board;
  int          cycles;
  int          rx_wait;
  // recently entered ids per link, to aim arrivals at queued trains
  logic [7:0]  recent_id[64][$];

  in_order_completion_queue u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: randomly hold off tready after each word, check each accepted word
  always @(posedge clk) begin
    iocq_pkg::res_t got;
    int wait_n;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.status = m_axis_tdata[2:0];
      got.retired_train = m_axis_tdata[10:3];
      got.caller_retired = m_axis_tdata[11];
      got.first_on_link = m_axis_tdata[12];
      got.link_now_empty = m_axis_tdata[13];
      got.last = m_axis_tlast;
      board.check_word(got);
      wait_n = $urandom_range(0, 7);
      m_axis_tready <= (wait_n == 0);
      rx_wait <= (wait_n == 0) ? 0 : wait_n - 1;
    end else if (!m_axis_tready) begin
      if (rx_wait == 0) m_axis_tready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  task automatic send_item(logic op, logic [2:0] from_st, logic [2:0] to_st,
                           logic [7:0] id);
    int gap;
    gap = (cycles % 700 < 150) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, id, to_st, from_st, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_item(op, from_st, to_st, id);
    if (op == iocq_pkg::OP_ENTER) recent_id[from_st * 8 + to_st].push_back(id);
  endtask

  // Write the mask once every word has come back and the block settles
  task automatic write_mask(logic [63:0] m);
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_mask(m);
  endtask

  task automatic random_phase(int count, logic [2:0] hot_from, logic [2:0] hot_to);
    logic [2:0] f, t;
    logic [7:0] id;
    int link;
    int q;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        f = hot_from ^ 3'($urandom_range(0, 1));
        t = hot_to;
      end else begin
        f = 3'($urandom_range(0, 7));
        t = 3'($urandom_range(0, 7));
      end
      link = f * 8 + t;
      if ($urandom_range(0, 1) == 0) begin
        id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 255)
                                         : 8'($urandom_range(0, 255));
        send_item(iocq_pkg::OP_ENTER, f, t, id);
      end else begin
        q = recent_id[link].size();
        if (q > 0 && $urandom_range(0, 5) != 0)
          id = recent_id[link][$urandom_range(0, q - 1)];
        else
          id = 8'($urandom_range(0, 255));
        send_item(iocq_pkg::OP_ARRIVE, f, t, id);
      end
      if (recent_id[link].size() > 16) void'(recent_id[link].pop_front());
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    board.set_mask('0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (80) @(posedge clk);

    // Directed: reset mask rejects everything
    send_item(iocq_pkg::OP_ENTER, 3'd0, 3'd0, 8'd1);
    write_mask({64{1'b1}});
    // Fill link 7->7 past full, ids at extremes and duplicates
    send_item(iocq_pkg::OP_ENTER, 3'd7, 3'd7, 8'd0);
    send_item(iocq_pkg::OP_ENTER, 3'd7, 3'd7, 8'd255);
    send_item(iocq_pkg::OP_ENTER, 3'd7, 3'd7, 8'd5);
    send_item(iocq_pkg::OP_ENTER, 3'd7, 3'd7, 8'd5);
    for (int k = 0; k < 5; k++) send_item(iocq_pkg::OP_ENTER, 3'd7, 3'd7, 8'(10 + k));
    // Later train arrives first, unknown train, then heads release
    send_item(iocq_pkg::OP_ARRIVE, 3'd7, 3'd7, 8'd5);
    send_item(iocq_pkg::OP_ARRIVE, 3'd7, 3'd7, 8'd99);
    send_item(iocq_pkg::OP_ARRIVE, 3'd7, 3'd7, 8'd255);
    send_item(iocq_pkg::OP_ARRIVE, 3'd7, 3'd7, 8'd0);
    for (int k = 0; k < 5; k++) send_item(iocq_pkg::OP_ARRIVE, 3'd7, 3'd7, 8'(14 - k));
    send_item(iocq_pkg::OP_ARRIVE, 3'd7, 3'd7, 8'd5);
    send_item(iocq_pkg::OP_ARRIVE, 3'd0, 3'd0, 8'd1);
    // Single-link mask: link 1->2 only
    write_mask(64'h1 << 10);
    send_item(iocq_pkg::OP_ENTER, 3'd1, 3'd2, 8'd7);
    send_item(iocq_pkg::OP_ENTER, 3'd2, 3'd1, 8'd7);
    send_item(iocq_pkg::OP_ARRIVE, 3'd1, 3'd2, 8'd7);

    // Random phases under several masks
    write_mask({64{1'b1}});
    random_phase(160, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    write_mask({$urandom, $urandom});
    random_phase(150, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    write_mask(64'h8000_0000_0000_0001 | {$urandom, $urandom} | 64'h0101_0101_0101_0101);
    random_phase(140, 3'd0, 3'd0);

    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
